[design/pu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pu_pkg: shared types and constants of the phase unwrapper
// cordic constants, pipeline word types and the arctangent table builder
// ----------------------------------------------------------------------------
package pu_pkg;

    // internal angle scale is 2^60 per pi
    localparam int CORDIC_W     = 64;
    localparam int CORDIC_STEPS = 62;
    localparam int NORM_W       = 61;
    localparam int NORM_STAGES  = 6;
    localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E441529;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_INT = 64'sd1 <<< 59;

    typedef struct packed {
        logic first;
        logic re_neg;
        logic im_neg;
        logic swapped;
        logic min_zero;
        logic both_zero;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [NORM_W-1:0] ax;
        logic [NORM_W-1:0] ay;
    } t_norm;

    typedef struct packed {
        t_side                      side;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } t_rot;

    // atan(2^-step) in units of 2^60 per pi, built from a truncated series
    function automatic logic signed [CORDIC_W-1:0] atan_entry(input int step);
        logic signed [63:0] rad;
        logic [63:0]        term;
        logic [127:0]       prod;
        int                 e;
        logic signed [CORDIC_W-1:0] res;
        rad = '0;
        res = '0;
        if (step == 0) begin
            res = 64'sd1 <<< 58;
        end else begin
            for (int n = 0; n < 32; n++) begin
                e = step * (2 * n + 1);
                if (e <= 62) begin
                    term = (64'd1 << (62 - e)) / 64'(2 * n + 1);
                    if (n % 2 == 1) begin
                        rad = rad - $signed(term);
                    end else begin
                        rad = rad + $signed(term);
                    end
                end
            end
            prod = {64'd0, rad} * {64'd0, TWO_OVER_PI_Q64};
            res  = $signed(prod[127:64] >> 3);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[design/pu_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pu_if: stream channels of the phase unwrapper
// sample channel in, unwrapped phase channel out, valid/ready handshake
// ----------------------------------------------------------------------------
interface pu_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          first_sample;
    logic signed [SAMPLE_BITS-1:0] real_part;
    logic signed [SAMPLE_BITS-1:0] imag_part;

    modport source (output valid, first_sample, real_part, imag_part, input ready);
    modport sink   (input valid, first_sample, real_part, imag_part, output ready);
endinterface

interface pu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] total_phase;
    logic               saturated;

    modport source (output valid, total_phase, saturated, input ready);
    modport sink   (input valid, total_phase, saturated, output ready);
endinterface
`default_nettype wire

[design/phase_unwrapper_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phase_unwrapper_top: running unwrapped phase of a complex sample stream
// atan2 by a chain of cordic cells, then unwrap and saturating accumulate
// ----------------------------------------------------------------------------
//
// channel  dir  payload                               word accepted when
// i_in     in   first_sample, real_part, imag_part    i_in.valid  && i_in.ready
// o_out    out  total_phase, saturated                o_out.valid && o_out.ready
//
// one word per cycle while o_out takes its words; 1 prep stage, 6 normalize
// cells, 62 cordic cells, 1 rounding stage, 1 output register
// every stage adds to the latency; cells move only when the chain advances
// reset clears all valid bits, the previous phase and the accumulator
// a held result stalls the chain only when the rounding stage is also full,
// so words keep entering while a result waits, until the rounding stage fills
//
module phase_unwrapper_top
    import pu_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int ANGLE_FRAC_BITS = 15
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    pu_in_if.sink     i_in,
    pu_out_if.source  o_out
);

    logic adv;

    // prep stage: magnitudes, octant swap and special-case flags
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic [SAMPLE_BITS-1:0]        mag_re;
    logic [SAMPLE_BITS-1:0]        mag_im;
    logic [SAMPLE_BITS-1:0]        mag_lo;
    logic [SAMPLE_BITS-1:0]        mag_hi;
    t_norm                         n_prep;
    logic                          r_prep_valid;
    t_norm                         r_prep;

    assign re = i_in.real_part;
    assign im = i_in.imag_part;

    always_comb begin
        // the most negative sample wraps to its true magnitude as unsigned
        mag_re = re[SAMPLE_BITS-1] ? SAMPLE_BITS'(-re) : re;
        mag_im = im[SAMPLE_BITS-1] ? SAMPLE_BITS'(-im) : im;
        n_prep.side.first     = i_in.first_sample;
        n_prep.side.re_neg    = re[SAMPLE_BITS-1];
        n_prep.side.im_neg    = im[SAMPLE_BITS-1];
        n_prep.side.swapped   = mag_im > mag_re;
        mag_hi = n_prep.side.swapped ? mag_im : mag_re;
        mag_lo = n_prep.side.swapped ? mag_re : mag_im;
        n_prep.side.min_zero  = mag_lo == '0;
        n_prep.side.both_zero = (mag_re == '0) && (mag_im == '0);
        n_prep.ax = NORM_W'(mag_hi);
        n_prep.ay = NORM_W'(mag_lo);
    end

    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (adv) begin
            r_prep_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prep <= n_prep;
        end
    end

    // normalize chain: shifts of 32, 16, 8, 4, 2, 1 bring the larger
    // magnitude's leading one to bit 60
    logic  nv [0:NORM_STAGES];
    t_norm nd [0:NORM_STAGES];

    assign nv[0] = r_prep_valid;
    assign nd[0] = r_prep;

    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
        pu_norm_cell #(
            .SHIFT (2 ** (NORM_STAGES - 1 - k))
        ) u_norm_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (nv[k]),
            .i_data  (nd[k]),
            .o_valid (nv[k+1]),
            .o_data  (nd[k+1])
        );
    end

    // cordic chain: one rotation per cell, angle starts at zero
    logic rv [0:CORDIC_STEPS];
    t_rot rd [0:CORDIC_STEPS];

    assign rv[0]      = nv[NORM_STAGES];
    assign rd[0].side = nd[NORM_STAGES].side;
    assign rd[0].x    = $signed(CORDIC_W'(nd[NORM_STAGES].ax));
    assign rd[0].y    = $signed(CORDIC_W'(nd[NORM_STAGES].ay));
    assign rd[0].z    = '0;

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
        pu_cordic_cell #(
            .STEP (s)
        ) u_cordic_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (rv[s]),
            .i_data  (rd[s]),
            .o_valid (rv[s+1]),
            .o_data  (rd[s+1])
        );
    end

    // rounding, quadrant, unwrap, accumulator and output register
    pu_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rv[CORDIC_STEPS]),
        .i_data  (rd[CORDIC_STEPS]),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[design/pu_norm_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pu_norm_cell: one step of magnitude normalization
// shifts both magnitudes left by SHIFT when the top SHIFT bits of ax are all zero
// ----------------------------------------------------------------------------
module pu_norm_cell
    import pu_pkg::*;
#(
    parameter int SHIFT = 1
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_adv,
    input  wire   i_valid,
    input  t_norm i_data,
    output logic  o_valid,
    output t_norm o_data
);

    logic  r_valid;
    t_norm r_data;
    t_norm n_data;

    always_comb begin
        n_data = i_data;
        if (i_data.ax[NORM_W-1 -: SHIFT] == '0) begin
            n_data.ax = i_data.ax << SHIFT;
            n_data.ay = i_data.ay << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[design/pu_cordic_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pu_cordic_cell: one vectoring rotation of the cordic chain
// rotates toward y = 0 by atan(2^-STEP) and tracks the angle
// ----------------------------------------------------------------------------
module pu_cordic_cell
    import pu_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_adv,
    input  wire  i_valid,
    input  t_rot i_data,
    output logic o_valid,
    output t_rot o_data
);

    localparam logic signed [CORDIC_W-1:0] ATAN = atan_entry(STEP);

    logic                       r_valid;
    t_rot                       r_data;
    t_rot                       n_data;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;

    always_comb begin
        // arithmetic shift is a floor shift
        xs     = i_data.x >>> STEP;
        ys     = i_data.y >>> STEP;
        n_data = i_data;
        if (!i_data.y[CORDIC_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ATAN;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[design/pu_finish.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pu_finish: phase rounding, quadrant restore, unwrap and accumulate
// owns the output register and the accumulator state
// ----------------------------------------------------------------------------
module pu_finish
    import pu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 15
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  t_rot            i_data,
    output logic            o_adv,
    pu_out_if.source        o_out
);

    localparam int PW = ANGLE_FRAC_BITS + 2;
    localparam int DW = PW + 1;
    localparam int SH = 60 - ANGLE_FRAC_BITS;
    localparam int SW = 34;
    localparam logic signed [PW-1:0] PI_P = PW'(64'd1 << ANGLE_FRAC_BITS);
    localparam logic signed [DW-1:0] PI_D = DW'(64'd1 << ANGLE_FRAC_BITS);
    localparam logic signed [DW-1:0] TWO_PI_D = DW'(64'd1 << (ANGLE_FRAC_BITS + 1));
    localparam logic signed [SW-1:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [SW-1:0] SUM_MIN = -34'sd2147483648;
    localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 64'sd1 <<< (SH - 1);

    // stage a: instantaneous phase
    logic                       r_a_valid;
    logic                       r_a_first;
    logic signed [PW-1:0]       r_a_cur;
    logic signed [CORDIC_W-1:0] zf;
    logic signed [CORDIC_W-1:0] zr;
    logic [ANGLE_FRAC_BITS:0]   q;
    logic signed [PW-1:0]       qs;
    logic signed [PW-1:0]       n_a_cur;

    // stage b: output register and state
    logic                 r_out_valid;
    logic signed [31:0]   r_phase;
    logic                 r_sat;
    logic signed [PW-1:0] r_prev;
    logic signed [31:0]   r_acc;
    logic                 out_load;
    logic signed [DW-1:0] diff;
    logic signed [SW-1:0] sum;
    logic signed [31:0]   n_sum;
    logic                 n_sat;

    always_comb begin
        zf = i_data.side.min_zero ? '0 : i_data.z;
        if (i_data.side.swapped) begin
            zf = HALF_PI_INT - zf;
        end
        if (zf < 0) begin
            zf = '0;
        end
        if (zf > HALF_PI_INT) begin
            zf = HALF_PI_INT;
        end
        zr = zf + ROUND_HALF;
        q  = zr[SH+ANGLE_FRAC_BITS:SH];
        qs = $signed({1'b0, q});
        if (i_data.side.both_zero) begin
            n_a_cur = '0;
        end else if (!i_data.side.re_neg) begin
            n_a_cur = i_data.side.im_neg ? -qs : qs;
        end else begin
            n_a_cur = i_data.side.im_neg ? -(PI_P - qs) : (PI_P - qs);
        end
    end

    always_comb begin
        diff = $signed({r_a_cur[PW-1], r_a_cur}) - $signed({r_prev[PW-1], r_prev});
        if (diff > PI_D) begin
            diff = diff - TWO_PI_D;
        end else if (diff < -PI_D) begin
            diff = diff + TWO_PI_D;
        end
        if (r_a_first) begin
            sum = SW'(r_a_cur);
        end else begin
            sum = SW'(r_acc) + SW'(diff);
        end
        n_sat = 1'b0;
        n_sum = sum[31:0];
        if (sum > SUM_MAX) begin
            n_sum = 32'sh7fffffff;
            n_sat = 1'b1;
        end else if (sum < SUM_MIN) begin
            n_sum = 32'sh80000000;
            n_sat = 1'b1;
        end
    end

    // output slot free or being taken; an empty stage a lets the chain move anyway
    assign out_load = !r_out_valid || o_out.ready;
    assign o_adv    = out_load || !r_a_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_a_first <= i_data.side.first;
            r_a_cur   <= n_a_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_acc       <= '0;
        end else if (out_load) begin
            r_out_valid <= r_a_valid;
            if (r_a_valid) begin
                r_prev <= r_a_cur;
                r_acc  <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_a_valid) begin
            r_phase <= n_sum;
            r_sat   <= n_sat;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.total_phase = r_phase;
    assign o_out.saturated   = r_sat;

endmodule
`default_nettype wire

[design/pu_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pu_checker: port-level checks of the phase unwrapper
// handshake holds, saturation limits and input readiness
// ----------------------------------------------------------------------------
module pu_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_phase,
    input wire        i_sat
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_phase) && $stable(i_sat))
        else $error("result word changed while stalled");

    // a clamped sum sits at one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> i_phase == 32'h7fffffff || i_phase == 32'h80000000)
        else $error("saturated flag without limit value");

    // with the output slot empty the chain always moves
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output slot");

    // nothing is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word offered right after reset");

endmodule

bind phase_unwrapper_top pu_checker u_pu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_phase     (o_out.total_phase),
    .i_sat       (o_out.saturated)
);
`default_nettype wire

[sim/phase_unwrapper_top_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phase_unwrapper_top_test: self-checking bench for the phase unwrapper
// drives complex sample words through the input channel with random gaps,
// stalls the output channel at random, predicts every unwrapped phase word
// with a bit-exact cordic angle model and an unwrap/saturate accumulator,
// and compares each output word field by field in arrival order
// ----------------------------------------------------------------------------
module phase_unwrapper_top_test;

    localparam int     SAMPLE_BITS     = 16;
    localparam int     ANGLE_FRAC_BITS = 15;
    localparam int     ROT_STEPS       = 62;
    localparam int     PIPE_LATENCY    = 71;
    localparam int     STALL_LIMIT     = 4000;
    localparam int     REPORT_LIMIT    = 40;
    localparam int     RANDOM_WORDS    = 760;
    localparam int     DRIFT_STEPS     = 24;
    localparam longint PI_UNITS        = 64'sd1 <<< ANGLE_FRAC_BITS;
    localparam longint QUARTER_TURN    = 64'sd1 <<< 59;   // pi/2 at 2^60 per pi
    localparam int     ROUND_SHIFT     = 60 - ANGLE_FRAC_BITS;
    localparam longint ACC_MAX         = 64'sd2147483647;
    localparam longint ACC_MIN         = -64'sd2147483648;
    localparam logic [63:0] INV_HALF_PI_Q64 = 64'hA2F9836E4E441529;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic signed [31:0] phase;
        logic               sat;
    } phase_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pu_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
    pu_out_if                             out_if ();

    phase_unwrapper_top #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state, mirrors the block after reset
    longint      atan_steps [ROT_STEPS];
    longint      prev_angle  = 0;
    longint      acc_phase   = 0;
    phase_word_t phase_expected [$];
    phase_word_t exp_word;

    // bookkeeping
    logic idle_on     = 1'b0;
    int   stall_left  = 0;
    int   quiet_count = 0;
    int   fail_count  = 0;
    int   words_sent  = 0;
    int   words_seen  = 0;
    int   first_words = 0;
    int   sat_words   = 0;

    // atan(2^-i) at 2^60 per pi: alternating taylor terms in q62 radians,
    // scaled by 2/pi as a q64 fraction, then down to the internal scale
    function automatic void build_atan_steps();
        longint       rad;
        logic [63:0]  term;
        logic [127:0] prod;
        int           e;
        atan_steps[0] = 64'sd1 <<< 58;
        for (int i = 1; i < ROT_STEPS; i++) begin
            rad = 0;
            for (int n = 0; i * (2 * n + 1) <= 62; n++) begin
                e    = i * (2 * n + 1);
                term = (64'd1 << (62 - e)) / 64'(2 * n + 1);
                if (n % 2 == 1) begin
                    rad = rad - longint'(term);
                end else begin
                    rad = rad + longint'(term);
                end
            end
            prod          = {64'd0, rad} * {64'd0, INV_HALF_PI_Q64};
            atan_steps[i] = longint'(prod[127:64] >> 3);
        end
    endfunction

    // instantaneous phase in units of 2^ANGLE_FRAC_BITS per pi
    function automatic longint angle_of_sample(longint re, longint im);
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] t;
        logic        swapped;
        longint      x, y, z, xs, ys, q;
        ax      = (re < 0) ? -re : re;
        ay      = (im < 0) ? -im : im;
        swapped = 1'b0;
        z       = 0;
        if (ax == 0 && ay == 0) begin
            return 0;
        end
        if (ay > ax) begin
            t       = ax;
            ax      = ay;
            ay      = t;
            swapped = 1'b1;
        end
        // normalize so the larger leg has bit 60 set
        while (!ax[60]) begin
            ax = ax << 1;
            ay = ay << 1;
        end
        x = longint'(ax);
        y = longint'(ay);
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_steps[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_steps[i];
            end
        end
        if (ay == 0) begin
            z = 0;
        end
        if (swapped) begin
            z = QUARTER_TURN - z;
        end
        if (z < 0) begin
            z = 0;
        end
        if (z > QUARTER_TURN) begin
            z = QUARTER_TURN;
        end
        q = (z + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (re >= 0) begin
            return (im >= 0) ? q : -q;
        end
        return (im >= 0) ? (PI_UNITS - q) : -(PI_UNITS - q);
    endfunction

    // advance the unwrap accumulator by one accepted sample
    function automatic phase_word_t unwrap_step(logic first, sample_t re, sample_t im);
        longint      cur, diff, sum;
        phase_word_t w;
        cur = angle_of_sample(longint'(re), longint'(im));
        if (first) begin
            sum = cur;
        end else begin
            diff = cur - prev_angle;
            if (diff > PI_UNITS) begin
                diff = diff - 2 * PI_UNITS;
            end else if (diff < -PI_UNITS) begin
                diff = diff + 2 * PI_UNITS;
            end
            sum = acc_phase + diff;
        end
        w.sat = 1'b0;
        if (sum > ACC_MAX) begin
            sum   = ACC_MAX;
            w.sat = 1'b1;
        end else if (sum < ACC_MIN) begin
            sum   = ACC_MIN;
            w.sat = 1'b1;
        end
        acc_phase  = sum;
        prev_angle = cur;
        w.phase    = sum[31:0];
        return w;
    endfunction

    // one sample word: optional gap, then hold valid until the block takes it
    task automatic send_sample(input logic first, input sample_t re, input sample_t im);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.first_sample <= first;
        in_if.real_part    <= re;
        in_if.imag_part    <= im;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        phase_expected.push_back(unwrap_step(first, re, im));
        words_sent++;
        if (first) begin
            first_words++;
        end
    endtask

    // drop valid and hold off until every predicted word has come back
    task automatic wait_until_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait (phase_expected.size() == 0);
    endtask

    function automatic sample_t random_part(int kind);
        sample_t v;
        case (kind)
            0: begin
                v = sample_t'($urandom);
            end
            1: begin
                v = sample_t'($urandom_range(0, 8)) - sample_t'(4);
            end
            2: begin
                v = '0;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh8001;
                    2:       v = -16'sd1;
                    3:       v = 16'sd0;
                    4:       v = 16'sd1;
                    default: v = 16'sh7fff;
                endcase
            end
        endcase
        return v;
    endfunction

    // axes, corners, the +-pi boundary and a missing first flag after reset
    task automatic test_axes_and_corners();
        send_sample(1'b0, 16'sd0, 16'sd0);            // no first flag, prev phase 0
        send_sample(1'b0, -16'sd5, 16'sd0);           // +pi, step of exactly +pi
        send_sample(1'b0, 16'sd5, 16'sd0);            // step of exactly -pi
        send_sample(1'b1, 16'sd32767, 16'sd32767);
        send_sample(1'b0, 16'sh8000, 16'sh8000);
        send_sample(1'b0, 16'sh8000, 16'sd0);         // negative real axis
        send_sample(1'b0, 16'sd0, 16'sh8000);
        send_sample(1'b0, 16'sd0, 16'sd32767);
        send_sample(1'b0, 16'sd32767, 16'sh8000);
        send_sample(1'b0, 16'sh8000, 16'sd32767);
        send_sample(1'b1, 16'sd0, 16'sd0);            // both zero on a first word
        send_sample(1'b0, 16'sd1, -16'sd1);
        send_sample(1'b0, -16'sd1, -16'sd1);
        send_sample(1'b0, -16'sd1, 16'sd1);
        send_sample(1'b0, 16'sh8000, -16'sd1);        // rounds to exactly -pi
        send_sample(1'b0, 16'sh8000, 16'sd1);         // crossing to exactly +pi
        send_sample(1'b0, 16'sh8000, -16'sd1);        // and back across
        send_sample(1'b0, 16'sd32767, 16'sd1);
        send_sample(1'b1, 16'sd1, 16'sd32767);
        send_sample(1'b0, 16'sd32767, 16'sd0);
    endtask

    // mostly full-range samples, mixed with near-zero, axis and extreme
    // values and negated repeats that step by close to pi
    task automatic test_random_stream(input int count);
        logic    first;
        sample_t re, im, last_re, last_im;
        int      mode;
        last_re = '0;
        last_im = '0;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            first = ($urandom_range(0, 15) == 0);
            mode  = $urandom_range(0, 9);
            case (mode)
                6: begin
                    re = random_part(1);
                    im = random_part(1);
                end
                7: begin
                    re = $urandom_range(0, 1) ? random_part(2) : random_part(0);
                    im = (re == 0) ? random_part($urandom_range(0, 1) * 3) : random_part(2);
                end
                8: begin
                    re = random_part(3);
                    im = random_part(3);
                end
                9: begin
                    re = -last_re;
                    im = -last_im;
                end
                default: begin
                    re = random_part(0);
                    im = random_part(0);
                end
            endcase
            send_sample(first, re, im);
            last_re = re;
            last_im = im;
        end
    endtask

    // sender stops mid-stream until the pipeline has fully emptied
    task automatic test_pause_until_empty();
        idle_on = 1'b1;
        for (int n = 0; n < 12; n++) begin
            send_sample(n == 0, random_part(0), random_part(0));
        end
        wait_until_drained();
        for (int n = 0; n < 12; n++) begin
            send_sample(1'b0, random_part(0), random_part(0));
        end
    endtask

    // three points 120 degrees apart walk the accumulator steadily one way
    // over several turns, then a few steps walk it back
    task automatic test_drift(input logic rising, input int steps);
        sample_t re_pts [3];
        sample_t im_pts [3];
        int      k;
        re_pts = '{16'sd32767, -16'sd16384, -16'sd16384};
        im_pts = '{16'sd0, 16'sd28378, -16'sd28378};
        k      = 0;
        send_sample(1'b1, re_pts[0], im_pts[0]);
        for (int n = 0; n < steps; n++) begin
            k = rising ? (k + 1) % 3 : (k + 2) % 3;
            send_sample(1'b0, re_pts[k], im_pts[k]);
        end
        for (int n = 0; n < 3; n++) begin
            k = rising ? (k + 2) % 3 : (k + 1) % 3;
            send_sample(1'b0, re_pts[k], im_pts[k]);
        end
    endtask

    // output side backpressure in random bursts that start only while idle_on is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 10);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // result checker, oldest prediction first
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            words_seen++;
            if (phase_expected.size() == 0) begin
                if (fail_count < REPORT_LIMIT) begin
                    $error("unexpected output word: total_phase %0d saturated %0b",
                           out_if.total_phase, out_if.saturated);
                end
                fail_count++;
            end else begin
                exp_word = phase_expected.pop_front();
                if (exp_word.sat) begin
                    sat_words++;
                end
                if (out_if.total_phase !== exp_word.phase) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $error("total_phase mismatch: expected %0d, actual %0d",
                               $signed(exp_word.phase), out_if.total_phase);
                    end
                    fail_count++;
                end
                if (out_if.saturated !== exp_word.sat) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               exp_word.sat, out_if.saturated);
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_count <= 0;
        end else if (quiet_count >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.first_sample  = 1'b0;
        in_if.real_part     = '0;
        in_if.imag_part     = '0;
        out_if.ready        = 1'b0;
        build_atan_steps();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        test_axes_and_corners();
        test_random_stream(RANDOM_WORDS / 2);
        test_pause_until_empty();
        test_random_stream(RANDOM_WORDS / 2);

        // last part runs with no gaps and starts no new stall bursts
        idle_on = 1'b0;
        test_drift(1'b1, DRIFT_STEPS);
        test_drift(1'b0, DRIFT_STEPS);

        wait_until_drained();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        $display("covered %0d sample words (%0d block starts), %0d phase words checked",
                 words_sent, first_words, words_seen);
        $display("multi-turn phase walks in both directions, %0d clamped words seen",
                 sat_words);
        if (fail_count == 0 && phase_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
